/* hdl/shell_sort_selectable_gaps_top_defines.svh */
// assertion macros for the checker file
`ifndef SHELL_SORT_SELECTABLE_GAPS_TOP_DEFINES_SVH
`define SHELL_SORT_SELECTABLE_GAPS_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define SSG_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ssg check failed");

// next-cycle implication, sampled on clk, off during reset
`define SSG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ssg check failed");

`endif

/* hdl/ssg_pkg.sv */
// shared constants, types and gap sequence functions for the shell sorter
`default_nettype none

package ssg_pkg;

    localparam int MAX_ITEMS = 64;
    localparam int ADDR_W    = $clog2(MAX_ITEMS);
    localparam int CNT_W     = ADDR_W + 1;
    localparam int KEY_W     = 32;
    localparam int SWAP_W    = 11;
    localparam int GAP_W     = 7;
    localparam int MODE_W    = 2;

    localparam logic [SWAP_W-1:0] SWAP_MAX = '1;

    // gap sequence codes
    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SQUARE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_POW2   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_KNUTH  = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SORT_INIT,
        ST_PASS_START,
        ST_J_CHECK,
        ST_GET_T,
        ST_CMP,
        ST_PUT,
        ST_EMIT_RD,
        ST_EMIT_LD,
        ST_EMIT_WAIT
    } ssg_state_t;

    // controller to datapath commands
    typedef struct packed {
        logic store_key;
        logic sort_init;
        logic pass_start;
        logic next_gap;
        logic fetch_j;
        logic get_t;
        logic shift;
        logic put_t;
        logic emit_start;
        logic emit_rd;
        logic emit_load;
        logic emit_next;
        logic clear_set;
    } ssg_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic gap_zero;
        logic j_end;
        logic less;
        logic more_shift;
        logic out_last;
    } ssg_stat_t;

    // largest gap of the chosen sequence for a set of n keys
    function automatic logic [GAP_W-1:0] first_gap(input logic [MODE_W-1:0] mode,
                                                   input logic [CNT_W-1:0] n);
        int res;
        int v;
        int r;
        res = 1;
        v   = 1;
        case (mode)
            MODE_INSERT:
            begin
                res = 1;
            end
            MODE_SQUARE:
            begin
                for (r = 1; r <= 8; r++)
                begin
                    if (r * r <= int'(n))
                        res = r * r;
                end
            end
            MODE_POW2:
            begin
                for (r = 0; r < 7; r++)
                begin
                    if (v < int'(n))
                        v = 2 * v + 1;
                end
                res = v;
            end
            MODE_KNUTH:
            begin
                for (r = 0; r < 4; r++)
                begin
                    if (3 * v + 1 <= int'(n))
                        v = 3 * v + 1;
                end
                res = v;
            end
            default:
            begin
                res = 1;
            end
        endcase
        return GAP_W'(res);
    endfunction

    // gap that follows the given one, zero after the last pass
    function automatic logic [GAP_W-1:0] next_gap(input logic [MODE_W-1:0] mode,
                                                  input logic [GAP_W-1:0] gap);
        int res;
        int v;
        int r;
        res = 0;
        v   = 1;
        case (mode)
            MODE_INSERT:
            begin
                res = 0;
            end
            MODE_SQUARE:
            begin
                for (r = 1; r <= 8; r++)
                begin
                    if (r * r < int'(gap))
                        res = r * r;
                end
            end
            MODE_POW2:
            begin
                res = int'(gap >> 1);
            end
            MODE_KNUTH:
            begin
                for (r = 0; r < 5; r++)
                begin
                    if (v < int'(gap))
                        res = v;
                    v = 3 * v + 1;
                end
            end
            default:
            begin
                res = 0;
            end
        endcase
        return GAP_W'(res);
    endfunction

endpackage

`default_nettype wire

/* hdl/ssg_if.sv */
// handshake channels of the shell sorter: keys in, results out, mode config
`default_nettype none

interface ssg_key_if;
    logic                               valid;
    logic                               ready;
    logic signed [ssg_pkg::KEY_W-1:0]   key_value;
    logic                               is_last_input;

    modport source (output valid, output key_value, output is_last_input, input ready);
    modport sink   (input valid, input key_value, input is_last_input, output ready);
endinterface

interface ssg_res_if;
    logic                               valid;
    logic                               ready;
    logic signed [ssg_pkg::KEY_W-1:0]   sorted_key;
    logic                               is_last_result;
    logic [ssg_pkg::SWAP_W-1:0]         swap_count;
    logic                               overflow_dropped;

    modport source (output valid, output sorted_key, output is_last_result,
                    output swap_count, output overflow_dropped, input ready);
    modport sink   (input valid, input sorted_key, input is_last_result,
                    input swap_count, input overflow_dropped, output ready);
endinterface

interface ssg_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [ssg_pkg::MODE_W-1:0]         gap_mode;

    modport source (output valid, output gap_mode, input ready);
    modport sink   (input valid, input gap_mode, output ready);
endinterface

`default_nettype wire

/* hdl/ssg_dpath.sv */
// shell sorter datapath: key memory, counters, gap register, compare and output registers
`default_nettype none

module ssg_dpath (
    input  logic                               clk,
    input  logic                               rst_n,
    input  ssg_pkg::ssg_cmd_t                  cmd,
    output ssg_pkg::ssg_stat_t                 stat,
    input  logic signed [ssg_pkg::KEY_W-1:0]   key_value,
    input  logic                               cfg_wr,
    input  logic [ssg_pkg::MODE_W-1:0]         cfg_mode,
    output logic signed [ssg_pkg::KEY_W-1:0]   sorted_key,
    output logic                               is_last_result,
    output logic [ssg_pkg::SWAP_W-1:0]         swap_count,
    output logic                               overflow_dropped
);

    logic [ssg_pkg::KEY_W-1:0]  mem [ssg_pkg::MAX_ITEMS];

    logic [ssg_pkg::MODE_W-1:0] mode_reg;
    logic [ssg_pkg::CNT_W-1:0]  count_reg;
    logic                       ovf_reg;
    logic [ssg_pkg::SWAP_W-1:0] swap_reg;
    logic [ssg_pkg::GAP_W-1:0]  gap_reg;
    logic [ssg_pkg::CNT_W-1:0]  j_reg;
    logic [ssg_pkg::CNT_W-1:0]  k_reg;
    logic [ssg_pkg::KEY_W-1:0]  t_reg;
    logic [ssg_pkg::KEY_W-1:0]  rd_data_reg;
    logic [ssg_pkg::KEY_W-1:0]  key_out_reg;
    logic                       last_out_reg;

    logic [ssg_pkg::GAP_W-1:0]  k_minus_g;
    logic [ssg_pkg::GAP_W-1:0]  k_minus_2g;
    logic                       count_full;
    logic                       rd_en;
    logic [ssg_pkg::ADDR_W-1:0] rd_addr;
    logic                       wr_en;
    logic [ssg_pkg::ADDR_W-1:0] wr_addr;
    logic [ssg_pkg::KEY_W-1:0]  wr_data;

    // address arithmetic for the gapped walk
    assign k_minus_g  = ssg_pkg::GAP_W'(k_reg) - gap_reg;
    assign k_minus_2g = k_minus_g - gap_reg;
    assign count_full = (count_reg == ssg_pkg::CNT_W'(ssg_pkg::MAX_ITEMS));

    // memory read port select
    always_comb
    begin
        rd_en   = cmd.fetch_j | cmd.get_t | cmd.shift | cmd.emit_rd;
        rd_addr = j_reg[ssg_pkg::ADDR_W-1:0];
        if (cmd.get_t)
            rd_addr = k_minus_g[ssg_pkg::ADDR_W-1:0];
        else if (cmd.shift)
            rd_addr = k_minus_2g[ssg_pkg::ADDR_W-1:0];
    end

    // memory write port select
    always_comb
    begin
        wr_en   = (cmd.store_key & ~count_full) | cmd.shift | cmd.put_t;
        wr_addr = k_reg[ssg_pkg::ADDR_W-1:0];
        wr_data = t_reg;
        if (cmd.store_key)
        begin
            wr_addr = count_reg[ssg_pkg::ADDR_W-1:0];
            wr_data = key_value;
        end
        else if (cmd.shift)
        begin
            wr_data = rd_data_reg;
        end
    end

    // key memory, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    // mode register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= ssg_pkg::MODE_INSERT;
        else if (cfg_wr)
            mode_reg <= cfg_mode;
    end

    // set bookkeeping: count, overflow flag, swap total
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            swap_reg  <= '0;
        end
        else if (cmd.clear_set)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            swap_reg  <= '0;
        end
        else
        begin
            if (cmd.store_key)
            begin
                if (count_full)
                    ovf_reg <= 1'b1;
                else
                    count_reg <= count_reg + 1'b1;
            end
            if (cmd.sort_init)
                swap_reg <= '0;
            else if (cmd.shift && swap_reg != ssg_pkg::SWAP_MAX)
                swap_reg <= swap_reg + 1'b1;
        end
    end

    // gap, outer index and walking index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_reg <= '0;
            j_reg   <= '0;
            k_reg   <= '0;
        end
        else
        begin
            if (cmd.sort_init)
                gap_reg <= ssg_pkg::first_gap(mode_reg, count_reg);
            else if (cmd.next_gap)
                gap_reg <= ssg_pkg::next_gap(mode_reg, gap_reg);

            if (cmd.pass_start)
                j_reg <= ssg_pkg::CNT_W'(gap_reg);
            else if (cmd.emit_start)
                j_reg <= '0;
            else if (cmd.put_t || cmd.emit_next)
                j_reg <= j_reg + 1'b1;

            if (cmd.fetch_j)
                k_reg <= j_reg;
            else if (cmd.shift)
                k_reg <= ssg_pkg::CNT_W'(k_minus_g);
        end
    end

    // held key and output payload
    always_ff @(posedge clk)
    begin
        if (cmd.get_t)
            t_reg <= rd_data_reg;
        if (cmd.emit_load)
        begin
            key_out_reg  <= rd_data_reg;
            last_out_reg <= (j_reg == count_reg - 1'b1);
        end
    end

    // status to controller
    always_comb
    begin
        stat.gap_zero   = (gap_reg == '0);
        stat.j_end      = (j_reg >= count_reg);
        stat.less       = ($signed(t_reg) < $signed(rd_data_reg));
        stat.more_shift = (k_minus_g >= gap_reg);
        stat.out_last   = last_out_reg;
    end

    assign sorted_key       = key_out_reg;
    assign is_last_result   = last_out_reg;
    assign swap_count       = swap_reg;
    assign overflow_dropped = ovf_reg;

endmodule

`default_nettype wire

/* hdl/ssg_ctrl.sv */
// shell sorter controller: load, gapped insertion passes, result emission
`default_nettype none

module ssg_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                key_valid,
    input  logic                key_last,
    output logic                key_ready,
    output logic                res_valid,
    input  logic                res_ready,
    input  ssg_pkg::ssg_stat_t  stat,
    output ssg_pkg::ssg_cmd_t   cmd
);

    ssg_pkg::ssg_state_t state_reg;
    ssg_pkg::ssg_state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ssg_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ssg_pkg::ST_IDLE:
            begin
                if (key_valid && key_last)
                    state_next = ssg_pkg::ST_SORT_INIT;
            end
            ssg_pkg::ST_SORT_INIT:
            begin
                state_next = ssg_pkg::ST_PASS_START;
            end
            ssg_pkg::ST_PASS_START:
            begin
                if (stat.gap_zero)
                    state_next = ssg_pkg::ST_EMIT_RD;
                else
                    state_next = ssg_pkg::ST_J_CHECK;
            end
            ssg_pkg::ST_J_CHECK:
            begin
                if (stat.j_end)
                    state_next = ssg_pkg::ST_PASS_START;
                else
                    state_next = ssg_pkg::ST_GET_T;
            end
            ssg_pkg::ST_GET_T:
            begin
                state_next = ssg_pkg::ST_CMP;
            end
            ssg_pkg::ST_CMP:
            begin
                if (!stat.less)
                    state_next = ssg_pkg::ST_J_CHECK;
                else if (!stat.more_shift)
                    state_next = ssg_pkg::ST_PUT;
            end
            ssg_pkg::ST_PUT:
            begin
                state_next = ssg_pkg::ST_J_CHECK;
            end
            ssg_pkg::ST_EMIT_RD:
            begin
                state_next = ssg_pkg::ST_EMIT_LD;
            end
            ssg_pkg::ST_EMIT_LD:
            begin
                state_next = ssg_pkg::ST_EMIT_WAIT;
            end
            ssg_pkg::ST_EMIT_WAIT:
            begin
                if (res_ready)
                begin
                    if (stat.out_last)
                        state_next = ssg_pkg::ST_IDLE;
                    else
                        state_next = ssg_pkg::ST_EMIT_RD;
                end
            end
            default:
            begin
                state_next = ssg_pkg::ST_IDLE;
            end
        endcase
    end

    // command and handshake outputs
    always_comb
    begin
        cmd       = '0;
        key_ready = 1'b0;
        res_valid = 1'b0;
        case (state_reg)
            ssg_pkg::ST_IDLE:
            begin
                key_ready     = 1'b1;
                cmd.store_key = key_valid;
            end
            ssg_pkg::ST_SORT_INIT:
            begin
                cmd.sort_init = 1'b1;
            end
            ssg_pkg::ST_PASS_START:
            begin
                cmd.emit_start = stat.gap_zero;
                cmd.pass_start = ~stat.gap_zero;
            end
            ssg_pkg::ST_J_CHECK:
            begin
                cmd.next_gap = stat.j_end;
                cmd.fetch_j  = ~stat.j_end;
            end
            ssg_pkg::ST_GET_T:
            begin
                cmd.get_t = 1'b1;
            end
            ssg_pkg::ST_CMP:
            begin
                cmd.shift = stat.less;
                cmd.put_t = ~stat.less;
            end
            ssg_pkg::ST_PUT:
            begin
                cmd.put_t = 1'b1;
            end
            ssg_pkg::ST_EMIT_RD:
            begin
                cmd.emit_rd = 1'b1;
            end
            ssg_pkg::ST_EMIT_LD:
            begin
                cmd.emit_load = 1'b1;
            end
            ssg_pkg::ST_EMIT_WAIT:
            begin
                res_valid     = 1'b1;
                cmd.clear_set = res_ready & stat.out_last;
                cmd.emit_next = res_ready & ~stat.out_last;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

/* hdl/shell_sort_selectable_gaps_top.sv */
// shell sorter top level: key channel, result channel and gap mode register
//
// keys arrive on the keys channel, one request per cycle while loading; the
// request with is_last_input set closes the set and starts the sort. up to 64
// keys are kept; later keys of the set are dropped and overflow_dropped is set.
// cfg writes gap_mode (0 insertion, 1 squares, 2 two-power minus one, 3 knuth);
// ready is always high, and writes belong between sets.
// sorting runs gapped insertion on a key memory with one read and one write
// port: per outer index an index check that reads the key, a step that holds
// it and a compare, one more compare per shifted key and a put step when a key
// moves to the front of its chain, plus a pass start and a final check per gap.
// results then leave in ascending order, one at a time, each after a memory
// read, a load of the output register and a handshake, carrying the set's
// swap total and overflow flag; is_last_result marks the final one.
// a stalled receiver holds the output register and the controller in place.
// no key is taken while a set is sorted or emitted.
// reset clears counts, flags and the mode; key memory needs no clearing.

`default_nettype none

module shell_sort_selectable_gaps_top (
    input  logic        clk,
    input  logic        rst_n,
    ssg_key_if.sink     keys,
    ssg_res_if.source   results,
    ssg_cfg_if.sink     cfg
);

    ssg_pkg::ssg_cmd_t  cmd;
    ssg_pkg::ssg_stat_t stat;

    // config port always accepts
    assign cfg.ready = 1'b1;

    // sequencer
    ssg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .key_valid (keys.valid),
        .key_last  (keys.is_last_input),
        .key_ready (keys.ready),
        .res_valid (results.valid),
        .res_ready (results.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // storage and arithmetic
    ssg_dpath u_dpath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .stat             (stat),
        .key_value        (keys.key_value),
        .cfg_wr           (cfg.valid),
        .cfg_mode         (cfg.gap_mode),
        .sorted_key       (results.sorted_key),
        .is_last_result   (results.is_last_result),
        .swap_count       (results.swap_count),
        .overflow_dropped (results.overflow_dropped)
    );

endmodule

`default_nettype wire

/* hdl/ssg_checker.sv */
// port-level checks of the shell sorter, bound to the top level
`default_nettype none

`include "shell_sort_selectable_gaps_top_defines.svh"

module ssg_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               keys_ready,
    input  logic                               res_valid,
    input  logic                               res_ready,
    input  logic signed [ssg_pkg::KEY_W-1:0]   res_key,
    input  logic                               res_last,
    input  logic [ssg_pkg::SWAP_W-1:0]         res_swap
);

    logic                               res_fire;
    logic                               have_prev_reg;
    logic signed [ssg_pkg::KEY_W-1:0]   prev_key_reg;
    logic [ssg_pkg::SWAP_W-1:0]         prev_swap_reg;

    assign res_fire = res_valid & res_ready;

    // previous result of the current set
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_prev_reg <= 1'b0;
            prev_key_reg  <= '0;
            prev_swap_reg <= '0;
        end
        else if (res_fire)
        begin
            have_prev_reg <= ~res_last;
            prev_key_reg  <= res_key;
            prev_swap_reg <= res_swap;
        end
    end

    // stalled result keeps its payload
    `SSG_ASSERT_NEXT(a_hold, res_valid && !res_ready,
        res_valid && $stable(res_key) && $stable(res_last) && $stable(res_swap))

    // loading and emitting never overlap
    `SSG_ASSERT_IMPLY(a_no_overlap, 1'b1, !(keys_ready && res_valid))

    // set ends cleanly after its last result
    `SSG_ASSERT_NEXT(a_set_end, res_fire && res_last, !res_valid)

    // results come out in ascending order
    `SSG_ASSERT_IMPLY(a_order, res_fire && have_prev_reg, res_key >= prev_key_reg)

    // swap total is the same on every result of a set
    `SSG_ASSERT_IMPLY(a_swap_const, res_fire && have_prev_reg, res_swap == prev_swap_reg)

endmodule

bind shell_sort_selectable_gaps_top ssg_checker u_ssg_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .keys_ready (keys.ready),
    .res_valid  (results.valid),
    .res_ready  (results.ready),
    .res_key    (results.sorted_key),
    .res_last   (results.is_last_result),
    .res_swap   (results.swap_count)
);

`default_nettype wire

/* bench/tb.sv */
// self-checking shell sorter bench: directed sets, an oversized set, random sets per gap mode
`default_nettype none

module tb;
    import ssg_pkg::*;

    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 8;
    localparam int DRAIN_CYCLES   = 20;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_KEYS    = 40;
    localparam int REPORT_LIMIT   = 10;
    localparam int SETS_PER_PHASE = 2;

    typedef logic signed [KEY_W-1:0] key_t;

    // one sorted key as it should leave the block
    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic                    last;
        logic [SWAP_W-1:0]       swaps;
        logic                    dropped;
    } sorted_t;

    // one directed request; known marks a lone key whose result is typed in
    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic                    last;
        logic [MODE_W-1:0]       mode;
        logic                    known;
    } row_t;

    // how the keys of a random set are drawn
    typedef enum int {
        FILL_WIDE,
        FILL_CLUSTER,
        FILL_FALLING,
        FILL_EXTREMES
    } fill_t;

    logic clk = 1'b0;
    logic rst_n;

    ssg_key_if keys_ch ();
    ssg_res_if res_ch ();
    ssg_cfg_if cfg_ch ();

    shell_sort_selectable_gaps_top dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .keys    (keys_ch),
        .results (res_ch),
        .cfg     (cfg_ch)
    );

    // directed sets: lone extremes, then one set per gap mode
    row_t directed [0:22] = '{
        {32'h80000000, 1'b1, MODE_INSERT, 1'b1},
        {32'h7fffffff, 1'b1, MODE_INSERT, 1'b1},
        {32'hffffffff, 1'b1, MODE_INSERT, 1'b1},
        // extremes out of order, plain insertion
        {32'h7fffffff, 1'b0, MODE_INSERT, 1'b0},
        {32'h80000000, 1'b0, MODE_INSERT, 1'b0},
        {32'h00000000, 1'b0, MODE_INSERT, 1'b0},
        {32'hffffffff, 1'b0, MODE_INSERT, 1'b0},
        {32'h00010000, 1'b1, MODE_INSERT, 1'b0},
        // reversed run, square gaps
        {32'h00050000, 1'b0, MODE_SQUARE, 1'b0},
        {32'h00040000, 1'b0, MODE_SQUARE, 1'b0},
        {32'h00030000, 1'b0, MODE_SQUARE, 1'b0},
        {32'h00020000, 1'b0, MODE_SQUARE, 1'b0},
        {32'h00010000, 1'b1, MODE_SQUARE, 1'b0},
        // equal keys, two-power gaps whose first gap is past the set
        {32'h00018000, 1'b0, MODE_POW2, 1'b0},
        {32'h00018000, 1'b0, MODE_POW2, 1'b0},
        {32'hfffe8000, 1'b0, MODE_POW2, 1'b0},
        {32'h00018000, 1'b1, MODE_POW2, 1'b0},
        // knuth gaps, neighbors of the extremes
        {32'h00050000, 1'b0, MODE_KNUTH, 1'b0},
        {32'hffff0000, 1'b0, MODE_KNUTH, 1'b0},
        {32'h00050000, 1'b0, MODE_KNUTH, 1'b0},
        {32'h80000001, 1'b0, MODE_KNUTH, 1'b0},
        {32'h7ffffffe, 1'b1, MODE_KNUTH, 1'b0},
        // back to insertion
        {32'h00000001, 1'b1, MODE_INSERT, 1'b1}
    };

    key_t extreme_keys [0:5] = '{
        32'h80000000, 32'h80000001, 32'hffffffff, 32'h00000000, 32'h7ffffffe, 32'h7fffffff
    };

    // shadow of the sorter
    key_t              held_keys [MAX_ITEMS];
    int                held_count;
    logic [SWAP_W-1:0] held_swaps;
    logic              held_dropped;
    logic [MODE_W-1:0] cur_mode;
    sorted_t           expected_sorted [$];

    // run bookkeeping
    logic calm = 1'b0;
    int   holds_asked = 0;
    int   holds_given = 0;
    int   keys_sent = 0;
    int   sets_closed = 0;
    int   dropped_sets = 0;
    int   mode_writes = 0;
    int   results_seen = 0;
    int   mismatches = 0;
    int   stuck_cycles = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // idle length: mostly none or short, now and then long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm)
            return 0;
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // one gapped insertion pass over the held keys
    function automatic void gapped_pass(input int gap, input int n);
        int   j;
        int   k;
        key_t t;
        for (j = gap; j < n; j++)
        begin
            k = j;
            while (k >= gap && held_keys[k] < held_keys[k - gap])
            begin
                t                  = held_keys[k];
                held_keys[k]       = held_keys[k - gap];
                held_keys[k - gap] = t;
                if (held_swaps != SWAP_MAX)
                    held_swaps++;
                k -= gap;
            end
        end
    endfunction

    // walk the gap sequence of the current mode from largest to 1
    function automatic void sort_held();
        int n;
        int g;
        n          = held_count;
        held_swaps = '0;
        case (cur_mode)
            MODE_INSERT:
            begin
                gapped_pass(1, n);
            end
            MODE_SQUARE:
            begin
                g = 1;
                while ((g + 1) * (g + 1) <= n)
                    g++;
                for (; g >= 1; g--)
                    gapped_pass(g * g, n);
            end
            MODE_POW2:
            begin
                g = 1;
                while (g < n)
                    g = 2 * g + 1;
                for (; g >= 1; g = (g - 1) / 2)
                    gapped_pass(g, n);
            end
            MODE_KNUTH:
            begin
                g = 1;
                while (3 * g + 1 <= n)
                    g = 3 * g + 1;
                for (; g >= 1; g = (g - 1) / 3)
                    gapped_pass(g, n);
            end
        endcase
    endfunction

    // store one key; a last key sorts the set and queues its results
    function automatic void absorb_key(input key_t key, input logic last);
        sorted_t r;
        int      i;
        if (held_count < MAX_ITEMS)
        begin
            held_keys[held_count] = key;
            held_count++;
        end
        else
        begin
            held_dropped = 1'b1;
        end
        if (last)
        begin
            sort_held();
            for (i = 0; i < held_count; i++)
            begin
                r.key     = held_keys[i];
                r.last    = (i == held_count - 1);
                r.swaps   = held_swaps;
                r.dropped = held_dropped;
                expected_sorted.insert(expected_sorted.size(), r);
            end
            sets_closed++;
            if (held_dropped)
                dropped_sets++;
            held_count   = 0;
            held_swaps   = '0;
            held_dropped = 1'b0;
        end
    endfunction

    function automatic key_t make_key(input fill_t fill, input int idx);
        int r;
        r = $urandom_range(0, 7);
        case (fill)
            FILL_WIDE:     return key_t'($urandom);
            FILL_CLUSTER:  return key_t'(($urandom_range(0, 6) - 3) * 65536);
            FILL_FALLING:  return key_t'((1000 - idx) * 65536 + r);
            FILL_EXTREMES: return (r < 6) ? extreme_keys[r] : key_t'($urandom);
        endcase
        return '0;
    endfunction

    // present one key request and wait for it to be taken
    task automatic offer_key(input key_t key, input logic last);
        int gap;
        gap = idle_len();
        if (gap > 0)
        begin
            keys_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        keys_ch.valid         <= 1'b1;
        keys_ch.key_value     <= key;
        keys_ch.is_last_input <= last;
        do
            @(posedge clk);
        while (!keys_ch.ready);
        keys_sent++;
    endtask

    task automatic feed_key(input key_t key, input logic last);
        offer_key(key, last);
        absorb_key(key, last);
    endtask

    // mode change only once every queued result has left
    task automatic set_gap_mode(input logic [MODE_W-1:0] mode);
        keys_ch.valid <= 1'b0;
        while (expected_sorted.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_ch.valid    <= 1'b1;
        cfg_ch.gap_mode <= mode;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        cur_mode = mode;
        mode_writes++;
    endtask

    // receiver: random ready gaps, plus the long hold when asked
    initial
    begin : receiver
        int rx_gap;
        int hold_left;
        rx_gap       = 0;
        hold_left    = 0;
        res_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (!rst_n)
            begin
                res_ch.ready <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end
            else if (holds_given < holds_asked && res_ch.valid)
            begin
                holds_given++;
                hold_left = HOLD_CYCLES - 1;
                res_ch.ready <= 1'b0;
            end
            else if (rx_gap > 0)
            begin
                rx_gap--;
                res_ch.ready <= 1'b0;
            end
            else
            begin
                res_ch.ready <= 1'b1;
                rx_gap = idle_len();
            end
        end
    end

    // compare each taken result with the oldest queued one
    always @(posedge clk)
    begin : result_check
        sorted_t got;
        sorted_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            got.key     = res_ch.sorted_key;
            got.last    = res_ch.is_last_result;
            got.swaps   = res_ch.swap_count;
            got.dropped = res_ch.overflow_dropped;
            results_seen++;
            if (expected_sorted.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected result: key %h last %0b swaps %0d dropped %0b",
                             got.key, got.last, got.swaps, got.dropped);
            end
            else
            begin
                want = expected_sorted.pop_front();
                if (got.key !== want.key || got.last !== want.last
                    || got.swaps !== want.swaps || got.dropped !== want.dropped)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("mismatch at result %0d: expected key %h last %0b swaps %0d %s%0b",
                                 results_seen, want.key, want.last, want.swaps, "dropped ",
                                 want.dropped);
                    if (mismatches <= REPORT_LIMIT)
                        $display("    got key %h last %0b swaps %0d dropped %0b",
                                 got.key, got.last, got.swaps, got.dropped);
                end
            end
        end
    end

    // watchdog on cycles in which no request moves
    always @(posedge clk)
    begin
        if ((keys_ch.valid && keys_ch.ready) || (res_ch.valid && res_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout: no request moved for %0d cycles", stuck_cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin : stimulus
        int      i;
        int      s;
        int      n;
        int      r;
        int      phase;
        int      random_keys;
        fill_t   fill;
        sorted_t lone;

        rst_n                 = 1'b0;
        keys_ch.valid         = 1'b0;
        keys_ch.key_value     = '0;
        keys_ch.is_last_input = 1'b0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.gap_mode       = MODE_INSERT;
        held_count            = 0;
        held_swaps            = '0;
        held_dropped          = 1'b0;
        cur_mode              = MODE_INSERT;
        random_keys           = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (i = 0; i < 23; i++)
        begin
            if (held_count == 0 && directed[i].mode != cur_mode)
                set_gap_mode(directed[i].mode);
            if (directed[i].known)
            begin
                // a lone key comes back as itself with no swaps
                offer_key(directed[i].key, directed[i].last);
                lone.key     = directed[i].key;
                lone.last    = 1'b1;
                lone.swaps   = '0;
                lone.dropped = 1'b0;
                expected_sorted.insert(expected_sorted.size(), lone);
                sets_closed++;
            end
            else
            begin
                feed_key(directed[i].key, directed[i].last);
            end
        end

        // oversized set: keys past the store are dropped; the receiver then
        // holds off while the next sets keep pushing at the input
        set_gap_mode(MODE_SQUARE);
        holds_asked++;
        for (i = 0; i < MAX_ITEMS + 3; i++)
            feed_key(key_t'($urandom), i == MAX_ITEMS + 2);

        // random sets, a few per gap mode, some phases without idling
        phase = 0;
        while (random_keys < RANDOM_KEYS)
        begin
            if (phase > 0)
                set_gap_mode((phase == 1) ? MODE_KNUTH :
                             (phase == 2) ? MODE_INSERT :
                             (phase == 3) ? MODE_POW2 : MODE_W'($urandom_range(0, 3)));
            calm = (phase % 3 == 2);
            for (s = 0; s < SETS_PER_PHASE && random_keys < RANDOM_KEYS; s++)
            begin
                r = $urandom_range(0, 99);
                if (r < 60)
                    n = $urandom_range(1, 8);
                else if (r < 90)
                    n = $urandom_range(9, 20);
                else
                    n = $urandom_range(21, MAX_ITEMS);
                // keep the random part near its key budget
                if (n > RANDOM_KEYS - random_keys)
                    n = RANDOM_KEYS - random_keys;
                fill = fill_t'($urandom_range(0, 3));
                for (i = 0; i < n; i++)
                begin
                    feed_key(make_key(fill, i), i == n - 1);
                    random_keys++;
                end
            end
            phase++;
        end

        // let every queued result drain
        keys_ch.valid <= 1'b0;
        while (expected_sorted.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d keys in %0d sets (%0d with dropped keys), checked %0d results",
                 keys_sent, sets_closed, dropped_sets, results_seen);
        $display("gap mode writes %0d, long receiver holds %0d, mismatches %0d",
                 mode_writes, holds_given, mismatches);
        if (mismatches == 0 && expected_sorted.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire

/* files.f */
+incdir+hdl
hdl/ssg_pkg.sv
hdl/ssg_if.sv
hdl/ssg_dpath.sv
hdl/ssg_ctrl.sv
hdl/shell_sort_selectable_gaps_top.sv
hdl/ssg_checker.sv
bench/tb.sv
